>>> design/assert_macros.svh
// assertion helpers used by tpdd_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> design/tpdd_pkg.sv
// ----------------------------------------------------------------------------
// tpdd_pkg
// Types, codes and decode helpers for the tablet packet deframer and decoder.
// ----------------------------------------------------------------------------
package tpdd_pkg;

  localparam int BUFFER_BYTES = 32;
  localparam int FRAME_LEN    = 7;
  localparam int QUEUE_DEPTH  = 2;

  localparam int IDX_W   = $clog2(BUFFER_BYTES + 1);
  localparam int SLOT_W  = $clog2(FRAME_LEN - 1);
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_CR = 8'h0D;

  // configuration register indexes
  localparam logic REG_EXTRA_BITS  = 1'b0;
  localparam logic REG_ERASER_MASK = 1'b1;

  localparam logic [1:0] EXTRA_BITS_RESET  = 2'd1;
  localparam logic [3:0] ERASER_MASK_RESET = 4'd4;

  localparam logic KIND_RELEASE  = 1'b0;
  localparam logic KIND_POSITION = 1'b1;

  localparam logic [3:0] DEV_NONE   = 4'h0;
  localparam logic [3:0] DEV_STYLUS = 4'h2;
  localparam logic [3:0] DEV_ERASER = 4'hA;
  localparam logic [3:0] DEV_CURSOR = 4'h6;

  typedef enum logic [1:0] {
    TOOL_NONE   = 2'd0,
    TOOL_STYLUS = 2'd1,
    TOOL_ERASER = 2'd2,
    TOOL_CURSOR = 2'd3
  } tool_t;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    logic        report_kind;
    tool_t       tool_kind;
    logic        in_proximity;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [8:0]  pressure;
    logic [3:0]  buttons;
    logic [3:0]  device_code;
    logic        last;
  } report_t;

  function automatic tool_t frame_tool(frame_t d, logic [3:0] mask);
    tool_t t;
    if (!d[0][5]) begin
      t = TOOL_CURSOR;
    end else if ((d[3][6:3] & mask) != 4'd0) begin
      t = TOOL_ERASER;
    end else begin
      t = TOOL_STYLUS;
    end
    return t;
  endfunction

  function automatic report_t decode_frame(frame_t d, logic [1:0] extra, logic [3:0] mask);
    report_t r;
    logic [8:0] z;
    tool_t t;
    t = frame_tool(d, mask);
    // sign bit of the pressure field moves up with each extra bit
    case (extra)
      2'd0:    z = {2'b00, d[6][6:0] ^ 7'h40};
      2'd1:    z = {1'b0, {d[6][6:0], d[3][2]} ^ 8'h80};
      default: z = {d[6][6:0], d[3][2], d[0][2]} ^ 9'h100;
    endcase
    r.report_kind  = KIND_POSITION;
    r.tool_kind    = t;
    r.in_proximity = d[0][6];
    r.pos_x        = {d[0][1:0], d[1][6:0], d[2][6:0]};
    r.pos_y        = {d[3][1:0], d[4][6:0], d[5][6:0]};
    r.pressure     = z;
    r.buttons      = d[3][6:3];
    case (t)
      TOOL_STYLUS: r.device_code = DEV_STYLUS;
      TOOL_ERASER: r.device_code = DEV_ERASER;
      default:     r.device_code = DEV_CURSOR;
    endcase
    if (!d[0][6]) begin
      r.device_code = DEV_NONE;
    end
    r.last = 1'b1;
    return r;
  endfunction

  function automatic report_t release_report(tool_t t);
    report_t r;
    r = '0;
    r.report_kind = KIND_RELEASE;
    r.tool_kind   = t;
    return r;
  endfunction

endpackage

>>> design/tpdd_front.sv
// ----------------------------------------------------------------------------
// tpdd_front
// Byte deframer: tracks frame position, buffers sync frame bytes and hands
// each complete seven-byte sync frame to the queue.
// ----------------------------------------------------------------------------
module tpdd_front import tpdd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       push_valid,
  input  logic       push_ready,
  output frame_t     push_data
);

  logic [IDX_W-1:0] byte_index;
  logic [IDX_W-1:0] byte_index_next;
  logic             first_byte_sync;
  logic             sync_now;
  logic [7:0]       frame_bytes [FRAME_LEN-1];

  logic [IDX_W-1:0] idx_start;
  logic [IDX_W-1:0] idx_pos;
  logic [IDX_W-1:0] idx_inc;
  logic             frame_done;
  logic             take;

  assign rx_ready = push_ready;
  assign take     = rx_valid && rx_ready;

  always_comb begin
    idx_start = rx_byte[7] ? '0 : byte_index;
    // ascii buffer overflow drops back to the start
    idx_pos   = (idx_start >= IDX_W'(BUFFER_BYTES)) ? '0 : idx_start;
    sync_now  = (idx_pos == '0) ? rx_byte[7] : first_byte_sync;
    idx_inc   = idx_pos + 1'b1;
    frame_done = (idx_inc == IDX_W'(FRAME_LEN)) && sync_now;
    if (frame_done) begin
      byte_index_next = '0;
    end else if ((rx_byte == CHAR_CR) && !sync_now) begin
      byte_index_next = '0;
    end else begin
      byte_index_next = idx_inc;
    end
  end

  always_comb begin
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      push_data[i] = frame_bytes[i];
    end
    push_data[FRAME_LEN-1] = rx_byte;
  end

  assign push_valid = rx_valid && frame_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= '0;
      first_byte_sync <= 1'b0;
    end else if (take) begin
      byte_index      <= byte_index_next;
      first_byte_sync <= sync_now;
    end
  end

  always_ff @(posedge clk) begin
    if (take && (idx_pos < IDX_W'(FRAME_LEN - 1))) begin
      frame_bytes[idx_pos[SLOT_W-1:0]] <= rx_byte;
    end
  end

endmodule

>>> design/tpdd_queue.sv
// ----------------------------------------------------------------------------
// tpdd_queue
// Short frame queue between the deframer and the report generator.
// ----------------------------------------------------------------------------
module tpdd_queue import tpdd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  frame_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output frame_t pop_data
);

  frame_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> design/tpdd_back.sv
// ----------------------------------------------------------------------------
// tpdd_back
// Report generator: decodes queued frames, inserts a release report on a
// tool change and drives the registered report output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpdd_back import tpdd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] extra_bits,
  input  logic [3:0] erase_bits,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  frame_t     pop_data,
  output logic       report_valid,
  input  logic       report_ready,
  output report_t    report
);

  frame_t  work;
  logic    work_valid;
  tool_t   previous_tool;
  tool_t   cur_tool;
  logic    out_free;
  logic    fire;
  logic    need_release;
  report_t report_next;

  assign cur_tool     = frame_tool(work, erase_bits);
  assign need_release = (previous_tool != TOOL_NONE) && (cur_tool != previous_tool);
  assign out_free     = !report_valid || report_ready;
  assign fire         = work_valid && out_free;
  // frame stays in the work register for one more transfer after a release
  assign pop_ready    = !work_valid || (fire && !need_release);

  always_comb begin
    if (need_release) begin
      report_next = release_report(previous_tool);
    end else begin
      report_next = decode_frame(work, extra_bits, erase_bits);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid    <= 1'b0;
      previous_tool <= TOOL_NONE;
      report_valid  <= 1'b0;
    end else begin
      if (pop_ready) begin
        work_valid <= pop_valid;
      end
      if (fire) begin
        previous_tool <= cur_tool;
        report_valid  <= 1'b1;
      end else if (report_ready) begin
        report_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      work <= pop_data;
    end
    if (fire) begin
      report <= report_next;
    end
  end

  `ASSERT_CLK(a_last_marks_position, clk, rst,
    report_valid |-> ((report.report_kind == KIND_POSITION) == report.last),
    "last flag does not match report kind")
  `ASSERT_NEVER(a_release_has_tool, clk, rst,
    report_valid && (report.report_kind == KIND_RELEASE) && (report.tool_kind == TOOL_NONE),
    "release report without a tool")
  `ASSERT_CLK(a_release_keeps_frame, clk, rst,
    (fire && need_release) |=> (work_valid && !need_release),
    "frame lost after release report")
  `ASSERT_CLK(a_tool_sticks, clk, rst,
    (previous_tool != TOOL_NONE) |=> (previous_tool != TOOL_NONE),
    "previous tool returned to none")

endmodule

>>> design/tablet_packet_deframer_decoder_top.sv
// ----------------------------------------------------------------------------
// tablet_packet_deframer_decoder_top
// Pen tablet serial deframer and packet decoder.
//
//   channel   signals                         width  role
//   rx        rx_valid/rx_ready, rx_byte       8      serial byte in
//   report    report_valid/report_ready, ...   54     decoded report out
//   config    cfg_we, cfg_index, cfg_data      1+1+4  register write
//
// One byte is taken per cycle while the frame queue has room.
// A frame's report passes the frame queue, work register and report register
// after its seventh byte; a tool change adds a release report ahead of it.
// The report register frees the input side: a stalled output fills the
// two-entry frame queue before rx_ready drops.
// Synchronous reset, no clearing pass; frame buffer bytes have no reset.
// ----------------------------------------------------------------------------
module tablet_packet_deframer_decoder_top import tpdd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        report_valid,
  input  logic        report_ready,
  output logic        report_kind,
  output logic [1:0]  tool_kind,
  output logic        in_proximity,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic [8:0]  pressure,
  output logic [3:0]  buttons,
  output logic [3:0]  device_code,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  logic       extra_bits;
  logic [1:0] extra_pressure_bits;
  logic [3:0] eraser_button_mask;

  logic    push_valid;
  logic    push_ready;
  frame_t  push_data;
  logic    pop_valid;
  logic    pop_ready;
  frame_t  pop_data;
  report_t report;

  assign extra_bits = (cfg_index == REG_EXTRA_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      extra_pressure_bits <= EXTRA_BITS_RESET;
      eraser_button_mask  <= ERASER_MASK_RESET;
    end else if (cfg_we) begin
      if (extra_bits) begin
        extra_pressure_bits <= cfg_data[1:0];
      end else begin
        eraser_button_mask  <= cfg_data;
      end
    end
  end

  tpdd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tpdd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tpdd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .extra_bits   (extra_pressure_bits),
    .erase_bits   (eraser_button_mask),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report)
  );

  assign report_kind  = report.report_kind;
  assign tool_kind    = report.tool_kind;
  assign in_proximity = report.in_proximity;
  assign pos_x        = report.pos_x;
  assign pos_y        = report.pos_y;
  assign pressure     = report.pressure;
  assign buttons      = report.buttons;
  assign device_code  = report.device_code;
  assign last         = report.last;

endmodule
